@@ src/oscfar_pkg.sv @@
// Package for the ordered-statistic CFAR threshold unit.
// Holds widths, window constants, codes, state encoding and controller/datapath structs.
// Depends on nothing; every other file of the block imports it.
package oscfar_pkg;

  // Window and memory geometry.
  localparam int WINDOW_CELLS = 4;
  localparam int MEM_DEPTH    = 1024;
  localparam int HALF_CELLS   = WINDOW_CELLS / 2;
  localparam int ORDER_RANK   = (WINDOW_CELLS * 3) / 4;
  localparam int ORDER_IDX    = ORDER_RANK - 1;
  localparam int MEM_AW       = $clog2(MEM_DEPTH);
  localparam int CNT_W        = $clog2(WINDOW_CELLS);
  localparam int RANK_W       = $clog2(WINDOW_CELLS + 1);

  // Field widths.
  localparam int OP_W     = 1;
  localparam int ADDR_W   = 10;
  localparam int SAMPLE_W = 16;
  localparam int SCALE_W  = 16;
  localparam int LINE_W   = 11;
  localparam int STRIDE_W = 10;
  localparam int THR_W    = 32;
  localparam int EDGE_W   = 2;

  // Internal arithmetic widths.
  localparam int OFF_W  = STRIDE_W + $clog2(WINDOW_CELLS + 1);
  localparam int HALF_W = STRIDE_W + $clog2(HALF_CELLS + 1);
  localparam int LIM_W  = LINE_W + STRIDE_W;
  localparam int CMP_W  = ((LIM_W > HALF_W) ? LIM_W : HALF_W) + 2;
  localparam int GA_W   = ((OFF_W > MEM_AW) ? OFF_W : MEM_AW) + 2;

  // Configuration port.
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 2;

  localparam logic [SCALE_W-1:0]  SCALE_RST  = SCALE_W'(1);
  localparam logic [LINE_W-1:0]   LINE_RST   = LINE_W'(8);
  localparam logic [STRIDE_W-1:0] STRIDE_RST = STRIDE_W'(8);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SCALE  = 2'd0,
    REG_LINE   = 2'd1,
    REG_STRIDE = 2'd2
  } reg_e;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic [EDGE_W-1:0] {
    EDGE_BOTH  = 2'd0,
    EDGE_LEFT  = 2'd1,
    EDGE_RIGHT = 2'd2
  } edge_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_DECIDE,
    ST_GATHER,
    ST_DRAIN,
    ST_RANK,
    ST_LOAD
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic write;        // store the input word in the sample memory
    logic start;        // latch the cell under test
    logic setup;        // register line_cells * stride
    logic decide;       // pick the edge case and reset the gather offset
    logic gather;       // read one reference cell
    logic second_half;  // current reference cell lies after the cell under test
    logic half_wrap;    // last leading cell of a two-sided window
    logic rank;         // evaluate and rotate one candidate
    logic load;         // multiply and fill the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

@@ src/oscfar_ctrl.sv @@
// Controller state machine of the CFAR threshold unit.
// Sequences setup, gather, rank and load steps; uses oscfar_pkg.
module oscfar_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [oscfar_pkg::OP_W-1:0]  in_op_i,
  output logic                         in_stall_o,
  input  oscfar_pkg::status_t          status_i,
  output oscfar_pkg::cmd_t             cmd_o
);
  import oscfar_pkg::*;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               cnt_last;

  assign cnt_last = (cnt_q == CNT_W'(WINDOW_CELLS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_stall_o = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_op_i == OP_QUERY) begin
            cmd_o.start = 1'b1;
            state_d     = ST_SETUP;
          end else begin
            cmd_o.write = 1'b1;
          end
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d     = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd_o.decide = 1'b1;
        cnt_d        = '0;
        state_d      = ST_GATHER;
      end
      ST_GATHER: begin
        cmd_o.gather      = 1'b1;
        cmd_o.second_half = (cnt_q >= CNT_W'(HALF_CELLS));
        cmd_o.half_wrap   = (cnt_q == CNT_W'(HALF_CELLS - 1));
        if (cnt_last) begin
          cnt_d   = '0;
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_DRAIN: begin
        state_d = ST_RANK;
      end
      ST_RANK: begin
        cmd_o.rank = 1'b1;
        if (cnt_last) begin
          cnt_d   = '0;
          state_d = ST_LOAD;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_LOAD: begin
        if (status_i.out_free) begin
          cmd_o.load = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ src/oscfar_datapath.sv @@
// Datapath of the CFAR threshold unit: sample memory, gather addressing,
// rank selection, scaling multiplier and output register. Uses oscfar_pkg.
module oscfar_datapath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  oscfar_pkg::cmd_t                   cmd_i,
  output oscfar_pkg::status_t                status_o,
  input  logic [oscfar_pkg::ADDR_W-1:0]      in_address_i,
  input  logic [oscfar_pkg::SAMPLE_W-1:0]    in_sample_i,
  input  logic [oscfar_pkg::SCALE_W-1:0]     scale_i,
  input  logic [oscfar_pkg::LINE_W-1:0]      line_cells_i,
  input  logic [oscfar_pkg::STRIDE_W-1:0]    stride_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [oscfar_pkg::THR_W-1:0]       out_threshold_o,
  output logic [oscfar_pkg::SAMPLE_W-1:0]    out_ordered_value_o,
  output logic [oscfar_pkg::EDGE_W-1:0]      out_edge_case_o,
  output logic                               out_out_of_range_o
);
  import oscfar_pkg::*;

  logic [SAMPLE_W-1:0] mem [MEM_DEPTH];

  logic [ADDR_W-1:0]   addr_q;
  logic [LIM_W-1:0]    lim_q;
  edge_e               edge_q;
  logic [OFF_W-1:0]    off_q;
  logic                oor_q;
  logic [SAMPLE_W-1:0] rdata_q;
  logic                cap_q;
  logic [SAMPLE_W-1:0] cells_q [WINDOW_CELLS];
  logic [SAMPLE_W-1:0] ord_q;

  logic                out_valid_q;
  logic [THR_W-1:0]    thr_q;
  logic [SAMPLE_W-1:0] ordv_q;
  logic [EDGE_W-1:0]   edge_out_q;
  logic                oor_out_q;

  logic [HALF_W-1:0]   half;
  logic                is_left;
  logic                is_right;
  logic                minus;
  logic [GA_W-1:0]     ga;
  logic                ga_oor;
  logic [RANK_W-1:0]   cnt_lt;
  logic [RANK_W-1:0]   cnt_le;
  logic                hit;

  // Edge decision from the registered line limit.
  assign half     = HALF_W'(stride_i) * HALF_W'(HALF_CELLS);
  assign is_left  = (CMP_W'(addr_q) < CMP_W'(half));
  assign is_right = ((CMP_W'(addr_q) + CMP_W'(half)) >= CMP_W'(lim_q));

  // Gathered address, signed so that a negative reach is caught.
  assign minus  = (edge_q == EDGE_RIGHT) || ((edge_q == EDGE_BOTH) && !cmd_i.second_half);
  assign ga     = minus ? (GA_W'(addr_q) - GA_W'(off_q)) : (GA_W'(addr_q) + GA_W'(off_q));
  assign ga_oor = ga[GA_W-1] || (ga[GA_W-2:0] >= (GA_W-1)'(MEM_DEPTH));

  // Rank of the candidate in cells_q[0] against the whole window.
  always_comb begin
    cnt_lt = '0;
    cnt_le = '0;
    for (int i = 0; i < WINDOW_CELLS; i++) begin
      cnt_lt = cnt_lt + RANK_W'(cells_q[i] < cells_q[0]);
      cnt_le = cnt_le + RANK_W'(cells_q[i] <= cells_q[0]);
    end
  end
  assign hit = (cnt_lt <= RANK_W'(ORDER_IDX)) && (cnt_le > RANK_W'(ORDER_IDX));

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      mem[MEM_AW'(in_address_i)] <= in_sample_i;
    end
    if (cmd_i.gather && !ga_oor) begin
      rdata_q <= mem[ga[MEM_AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      addr_q <= in_address_i;
    end
    if (cmd_i.setup) begin
      lim_q <= LIM_W'(line_cells_i) * LIM_W'(stride_i);
    end
    if (cmd_i.decide) begin
      if (is_left) begin
        edge_q <= EDGE_LEFT;
      end else if (is_right) begin
        edge_q <= EDGE_RIGHT;
      end else begin
        edge_q <= EDGE_BOTH;
      end
      off_q <= OFF_W'(stride_i);
      oor_q <= 1'b0;
    end
    if (cmd_i.gather) begin
      if (cmd_i.half_wrap && (edge_q == EDGE_BOTH)) begin
        off_q <= OFF_W'(stride_i);
      end else begin
        off_q <= off_q + OFF_W'(stride_i);
      end
      oor_q <= oor_q | ga_oor;
    end
    if (cap_q) begin
      for (int i = 0; i < WINDOW_CELLS - 1; i++) begin
        cells_q[i] <= cells_q[i+1];
      end
      cells_q[WINDOW_CELLS-1] <= rdata_q;
    end else if (cmd_i.rank) begin
      for (int i = 0; i < WINDOW_CELLS; i++) begin
        cells_q[i] <= cells_q[(i + 1) % WINDOW_CELLS];
      end
      if (hit) begin
        ord_q <= cells_q[0];
      end
    end
    if (cmd_i.load) begin
      thr_q      <= oor_q ? '0 : (THR_W'(ord_q) * THR_W'(scale_i));
      ordv_q     <= oor_q ? '0 : ord_q;
      edge_out_q <= edge_q;
      oor_out_q  <= oor_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cap_q <= cmd_i.gather;
      if (cmd_i.load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o          = out_valid_q;
  assign out_threshold_o      = thr_q;
  assign out_ordered_value_o  = ordv_q;
  assign out_edge_case_o      = edge_out_q;
  assign out_out_of_range_o   = oor_out_q;

endmodule

@@ src/os_cfar_threshold_unit.sv @@
// Top level of the ordered-statistic CFAR threshold unit.
// Holds the configuration registers and joins oscfar_ctrl and oscfar_datapath; uses oscfar_pkg.
//
//   Channel  | Handshake                  | Word
//   ---------+----------------------------+------------------------------------------
//   input    | in_valid_i / in_stall_o    | op, address, sample
//   output   | out_valid_o / out_stall_i  | threshold, ordered_value, edge_case, oor
//   config   | psel/penable/pwrite/pready | scale_factor, line_cells, stride
//
// A write word stores its sample in memory on acceptance, and the block is ready
// again in the next cycle. A query word steps through registering line_cells*stride,
// deciding the edge case, one memory read per reference cell through the single read
// port, a drain step, one rank evaluation per reference cell, and the load.
// The result sits in an output register, so a new word is accepted while it waits;
// a later query waits in its load step until that register is free.
// Reset clears the controller and the output valid; the sample memory is not cleared.
module os_cfar_threshold_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Input channel.
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [oscfar_pkg::OP_W-1:0]          in_op_i,
  input  logic [oscfar_pkg::ADDR_W-1:0]        in_address_i,
  input  logic [oscfar_pkg::SAMPLE_W-1:0]      in_sample_i,
  // Output channel.
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [oscfar_pkg::THR_W-1:0]         out_threshold_o,
  output logic [oscfar_pkg::SAMPLE_W-1:0]      out_ordered_value_o,
  output logic [oscfar_pkg::EDGE_W-1:0]        out_edge_case_o,
  output logic                                 out_out_of_range_o,
  // Configuration port.
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [oscfar_pkg::PADDR_W-1:0]       paddr,
  input  logic [oscfar_pkg::PDATA_W-1:0]       pwdata,
  output logic [oscfar_pkg::PDATA_W-1:0]       prdata,
  output logic                                 pready
);
  import oscfar_pkg::*;

  logic [SCALE_W-1:0]   scale_q;
  logic [LINE_W-1:0]    line_q;
  logic [STRIDE_W-1:0]  stride_q;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;
  cmd_t                 cmd;
  status_t              status;

  // The port never inserts wait states. Registers sit on 32-bit word addresses.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q  <= SCALE_RST;
      line_q   <= LINE_RST;
      stride_q <= STRIDE_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_SCALE:  scale_q  <= pwdata[SCALE_W-1:0];
        REG_LINE:   line_q   <= pwdata[LINE_W-1:0];
        REG_STRIDE: stride_q <= pwdata[STRIDE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read data is zero-extended; the unused address reads as zero.
  always_comb begin
    case (reg_idx)
      REG_SCALE:  prdata = PDATA_W'(scale_q);
      REG_LINE:   prdata = PDATA_W'(line_q);
      REG_STRIDE: prdata = PDATA_W'(stride_q);
      default:    prdata = '0;
    endcase
  end

  oscfar_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_op_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  oscfar_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .status_o            (status),
    .in_address_i        (in_address_i),
    .in_sample_i         (in_sample_i),
    .scale_i             (scale_q),
    .line_cells_i        (line_q),
    .stride_i            (stride_q),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_threshold_o     (out_threshold_o),
    .out_ordered_value_o (out_ordered_value_o),
    .out_edge_case_o     (out_edge_case_o),
    .out_out_of_range_o  (out_out_of_range_o)
  );

endmodule

@@ src/oscfar_checker.sv @@
// Port-level checks for os_cfar_threshold_unit, bound to the top level.
// Sees only the top-level ports; uses oscfar_pkg for codes and widths.
module oscfar_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic [oscfar_pkg::OP_W-1:0]          in_op_i,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic [oscfar_pkg::THR_W-1:0]         out_threshold_o,
  input logic [oscfar_pkg::SAMPLE_W-1:0]      out_ordered_value_o,
  input logic [oscfar_pkg::EDGE_W-1:0]        out_edge_case_o,
  input logic                                 out_out_of_range_o
);
  import oscfar_pkg::*;

  // An accepted query keeps the input side busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (in_op_i == OP_QUERY)) |=> in_stall_o)
    else $error("input accepted right after a query");

  // After an accepted write word the input side is free again in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (in_op_i == OP_WRITE)) |=> !in_stall_o)
    else $error("write word left the block busy");

  // A new result only appears while a query is being worked on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without a query in progress");

  // A stalled result stays valid and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_threshold_o)
      && $stable(out_ordered_value_o) && $stable(out_edge_case_o)
      && $stable(out_out_of_range_o)))
    else $error("stalled result changed");

endmodule

bind os_cfar_threshold_unit oscfar_checker u_oscfar_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for os_cfar_threshold_unit: sample writes and threshold queries
// under several register settings, each threshold predicted and compared field by field.
// Depends on oscfar_pkg and the RTL of the unit; needs no other file.
module testbench;
  import oscfar_pkg::*;

  // Clock, pacing and run-length constants.
  localparam int CLK_HALF        = 5;
  localparam int RESET_CYCLES    = 3;
  localparam int QUERY_CYCLES    = 2 * WINDOW_CELLS + 5;
  localparam int SETTLE_CYCLES   = 2 * QUERY_CYCLES;
  localparam int IDLE_LIMIT      = 2000;
  localparam int MAX_REPORTS     = 10;
  localparam int RANDOM_PHASES   = 7;
  localparam int WORDS_PER_PHASE = 200;
  localparam int MAX_BURST       = 16;
  localparam int MAX_GAP         = 12;

  // One input word and one result word as the unit sees them.
  typedef struct packed {
    op_e                 op;
    logic [ADDR_W-1:0]   addr;
    logic [SAMPLE_W-1:0] sample;
  } cfar_word_t;

  typedef struct packed {
    logic [THR_W-1:0]    threshold;
    logic [SAMPLE_W-1:0] ordered;
    edge_e               side;
    logic                oor;
  } cfar_result_t;

  // Stimulus and ports. Every input of the unit starts at a known value.
  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                in_valid_i   = 1'b0;
  logic                in_stall_o;
  logic [OP_W-1:0]     in_op_i      = OP_WRITE;
  logic [ADDR_W-1:0]   in_address_i = '0;
  logic [SAMPLE_W-1:0] in_sample_i  = '0;
  logic                out_valid_o;
  logic                out_stall_i  = 1'b0;
  logic [THR_W-1:0]    out_threshold_o;
  logic [SAMPLE_W-1:0] out_ordered_value_o;
  logic [EDGE_W-1:0]   out_edge_case_o;
  logic                out_out_of_range_o;
  logic                psel         = 1'b0;
  logic                penable      = 1'b0;
  logic                pwrite       = 1'b0;
  logic [PADDR_W-1:0]  paddr        = '0;
  logic [PDATA_W-1:0]  pwdata       = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  // Predictor state: its own copy of the registers and of the sample memory.
  logic [SCALE_W-1:0]  cfg_scale  = SCALE_RST;
  logic [LINE_W-1:0]   cfg_line   = LINE_RST;
  logic [STRIDE_W-1:0] cfg_stride = STRIDE_RST;
  logic [SAMPLE_W-1:0] sample_store [MEM_DEPTH];

  // The generator keeps track of which cells hold a sample, so that no query
  // ever makes the unit read a cell that was never written.
  bit                  written_map [MEM_DEPTH];

  cfar_word_t   pending_words[$];
  cfar_result_t expected_results[$];
  cfar_word_t   next_word;
  cfar_result_t oldest_result;

  int fail_count      = 0;
  int words_made      = 0;
  int words_accepted  = 0;
  int queries_seen    = 0;
  int oor_seen        = 0;
  int side_count [3]  = '{0, 0, 0};
  int results_checked = 0;
  int reg_writes      = 0;
  int burst_left      = 1;
  int gap_left        = 0;
  int stall_mode      = 0;
  int mode_left       = 0;
  int stall_phase     = 0;
  int idle_cycles     = 0;

  os_cfar_threshold_unit dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .in_op_i             (in_op_i),
    .in_address_i        (in_address_i),
    .in_sample_i         (in_sample_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_threshold_o     (out_threshold_o),
    .out_ordered_value_o (out_ordered_value_o),
    .out_edge_case_o     (out_edge_case_o),
    .out_out_of_range_o  (out_out_of_range_o),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // Only the first few failures are printed in full; the rest are counted.
  function automatic void note_failure(input string msg);
    if (fail_count < MAX_REPORTS) begin
      $display("ERROR at %0t ns: %s", $time, msg);
    end
    fail_count++;
  endfunction

  // The left edge wins when the leading half of the window would fall below
  // address zero; the right edge holds when the trailing half reaches the end
  // of the line, which is line_cells strides long.
  function automatic edge_e window_side(input logic [ADDR_W-1:0] cut);
    int half;
    half = HALF_CELLS * int'(cfg_stride);
    if (int'(cut) < half) return EDGE_LEFT;
    if (int'(cut) + half >= int'(cfg_line) * int'(cfg_stride)) return EDGE_RIGHT;
    return EDGE_BOTH;
  endfunction

  // Address of reference cell j; it may be negative or past the memory.
  function automatic int ref_cell_addr(input logic [ADDR_W-1:0] cut, input edge_e side,
                                       input int j);
    int s;
    s = int'(cfg_stride);
    case (side)
      EDGE_LEFT:  return int'(cut) + (j + 1) * s;
      EDGE_RIGHT: return int'(cut) - (j + 1) * s;
      default: begin
        if (j < HALF_CELLS) return int'(cut) - (j + 1) * s;
        return int'(cut) + (j - HALF_CELLS + 1) * s;
      end
    endcase
  endfunction

  // Gathers the window, sorts it ascending and scales the selected rank.
  // Any cell outside the memory zeroes both the statistic and the threshold.
  function automatic cfar_result_t threshold_of(input logic [ADDR_W-1:0] cut);
    cfar_result_t        res;
    logic [SAMPLE_W-1:0] vals [WINDOW_CELLS];
    logic [SAMPLE_W-1:0] v;
    int                  a;
    int                  b;
    int                  ref_addr;
    res.side      = window_side(cut);
    res.oor       = 1'b0;
    res.ordered   = '0;
    res.threshold = '0;
    for (a = 0; a < WINDOW_CELLS; a++) begin
      ref_addr = ref_cell_addr(cut, res.side, a);
      if (ref_addr < 0 || ref_addr >= MEM_DEPTH) begin
        res.oor = 1'b1;
        vals[a] = '0;
      end else begin
        vals[a] = sample_store[ref_addr];
      end
    end
    if (!res.oor) begin
      for (a = 1; a < WINDOW_CELLS; a++) begin
        v = vals[a];
        b = a;
        while (b > 0 && vals[b-1] > v) begin
          vals[b] = vals[b-1];
          b--;
        end
        vals[b] = v;
      end
      res.ordered   = vals[ORDER_IDX];
      res.threshold = THR_W'(res.ordered) * THR_W'(cfg_scale);
    end
    return res;
  endfunction

  // Applies one accepted word to the predictor.
  task automatic predict_word(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                              input logic [SAMPLE_W-1:0] sample);
    cfar_result_t res;
    words_accepted++;
    if (op == OP_WRITE) begin
      if (int'(addr) < MEM_DEPTH) sample_store[addr] = sample;
    end else begin
      res = threshold_of(addr);
      expected_results.push_back(res);
      queries_seen++;
      side_count[res.side]++;
      if (res.oor) oor_seen++;
    end
  endtask

  // Magnitudes lean toward the two extremes now and then.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return SAMPLE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic push_write(input logic [ADDR_W-1:0] addr, input logic [SAMPLE_W-1:0] sample);
    cfar_word_t w;
    w.op     = OP_WRITE;
    w.addr   = addr;
    w.sample = sample;
    pending_words.push_back(w);
    written_map[addr] = 1'b1;
    words_made++;
  endtask

  // A query is preceded by writes to any cell of its window that holds no
  // sample yet. The sample field of a query carries random bits.
  task automatic push_query(input logic [ADDR_W-1:0] cut);
    cfar_word_t w;
    edge_e      side;
    int         j;
    int         ref_addr;
    side = window_side(cut);
    for (j = 0; j < WINDOW_CELLS; j++) begin
      ref_addr = ref_cell_addr(cut, side, j);
      if (ref_addr >= 0 && ref_addr < MEM_DEPTH && !written_map[ref_addr]) begin
        push_write(ADDR_W'(ref_addr), pick_sample());
      end
    end
    w.op     = OP_QUERY;
    w.addr   = cut;
    w.sample = SAMPLE_W'($urandom_range(0, 65535));
    pending_words.push_back(w);
    words_made++;
  endtask

  // Cells under test cluster around both edge boundaries part of the time.
  function automatic logic [ADDR_W-1:0] pick_cut();
    int c;
    case ($urandom_range(0, 3))
      0: c = HALF_CELLS * int'(cfg_stride) + int'($urandom_range(0, 6)) - 3;
      1: c = int'(cfg_line) * int'(cfg_stride) - HALF_CELLS * int'(cfg_stride)
             + int'($urandom_range(0, 6)) - 3;
      default: c = int'($urandom_range(0, MEM_DEPTH - 1));
    endcase
    if (c < 0) c = 0;
    if (c > MEM_DEPTH - 1) c = MEM_DEPTH - 1;
    return ADDR_W'(c);
  endfunction

  // One APB transfer: a setup cycle, then an access cycle that completes at
  // the next rising edge because pready is always high.
  task automatic apb_transfer(input logic wr, input reg_e idx, input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= PADDR_W'(4 * int'(idx));
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [PDATA_W-1:0] register_value(input reg_e idx);
    case (idx)
      REG_SCALE: return PDATA_W'(cfg_scale);
      REG_LINE:  return PDATA_W'(cfg_line);
      default:   return PDATA_W'(cfg_stride);
    endcase
  endfunction

  task automatic check_register(input reg_e idx);
    logic [PDATA_W-1:0] rd;
    apb_transfer(1'b0, idx, '0, rd);
    if (rd !== register_value(idx)) begin
      note_failure($sformatf("register %s reads %0d, expected %0d", idx.name(), rd,
                             register_value(idx)));
    end
  endtask

  // Writes a register, updates the predictor's copy and reads it back.
  task automatic cfg_write(input reg_e idx, input int value);
    logic [PDATA_W-1:0] rd;
    apb_transfer(1'b1, idx, PDATA_W'(value), rd);
    case (idx)
      REG_SCALE: cfg_scale  = SCALE_W'(value);
      REG_LINE:  cfg_line   = LINE_W'(value);
      default:   cfg_stride = STRIDE_W'(value);
    endcase
    reg_writes++;
    check_register(idx);
  endtask

  task automatic apply_settings(input int scale, input int line, input int stride);
    cfg_write(REG_SCALE, scale);
    cfg_write(REG_LINE, line);
    cfg_write(REG_STRIDE, stride);
  endtask

  // Waits until every word has gone in and every threshold has come out, then
  // lets the settle time of SETTLE_CYCLES pass so that a trailing write has surely landed.
  task automatic drain_and_settle();
    while (pending_words.size() != 0 || in_valid_i || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Directed part: each window side, windows leaving the memory at either end
  // and in the middle, the largest and smallest samples, scale and stride.
  task automatic run_directed();
    int k;
    // Reset settings: scale 1, eight cells of stride 8.
    push_write('0, '0);
    push_write('1, '1);
    push_query(ADDR_W'(0));
    push_query(ADDR_W'(24));
    push_query(ADDR_W'(60));
    push_query('1);
    drain_and_settle();
    // Widest stride: every window reaches past the end of memory.
    apply_settings(65535, 1024, 1023);
    push_query(ADDR_W'(0));
    push_query('1);
    drain_and_settle();
    // Single-cell line, unit stride: right edge almost everywhere, below zero
    // near the bottom, and the full-scale product at the top.
    apply_settings(65535, 1, 1);
    for (k = 1; k <= WINDOW_CELLS; k++) push_write(ADDR_W'(MEM_DEPTH - 1 - k), '1);
    push_query('1);
    push_query(ADDR_W'(2));
    push_query(ADDR_W'(1));
    drain_and_settle();
    // Zero scale on real windows, two-sided and right edge at the line end.
    apply_settings(0, 1024, 1);
    push_query(ADDR_W'(512));
    push_query(ADDR_W'(1021));
    push_query(ADDR_W'(1022));
    drain_and_settle();
    // A two-sided window whose upper half leaves the memory.
    apply_settings(3, 10, 300);
    push_query(ADDR_W'(700));
    drain_and_settle();
  endtask

  // Random register settings favor small strides and lines near the memory size.
  task automatic pick_settings();
    int sc;
    int st;
    int ln;
    case ($urandom_range(0, 3))
      0:       sc = 65535;
      1:       sc = int'($urandom_range(0, 3));
      default: sc = int'($urandom_range(0, 65535));
    endcase
    case ($urandom_range(0, 3))
      0:       st = int'($urandom_range(1, 4));
      1:       st = int'($urandom_range(1, 40));
      2:       st = int'($urandom_range(1, 200));
      default: st = int'($urandom_range(1, 1023));
    endcase
    case ($urandom_range(0, 3))
      0, 1:    ln = MEM_DEPTH / st + int'($urandom_range(0, 4)) - 2;
      2:       ln = int'($urandom_range(1, 1024));
      default: ln = ($urandom_range(0, 1) != 0) ? 1024 : 1;
    endcase
    if (ln < 1) ln = 1;
    if (ln > 1024) ln = 1024;
    apply_settings(sc, ln, st);
  endtask

  // Driver: bursts of words separated by random gaps. A stalled word is held
  // unchanged, and valid is never taken back before acceptance.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      in_op_i      <= OP_WRITE;
      in_address_i <= '0;
      in_sample_i  <= '0;
      burst_left   <= 1;
      gap_left     <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        predict_word(in_op_i, in_address_i, in_sample_i);
      end
      if (in_valid_i && in_stall_o) begin
        // The current word waits for the unit.
      end else if (gap_left != 0) begin
        gap_left   <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (pending_words.size() != 0) begin
        next_word = pending_words.pop_front();
        in_op_i      <= next_word.op;
        in_address_i <= next_word.addr;
        in_sample_i  <= next_word.sample;
        in_valid_i   <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= int'($urandom_range(1, MAX_BURST));
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, MAX_GAP));
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: checks each accepted result against the oldest prediction, and
  // stalls the output in modes that change after random stretches: never,
  // seldom, mostly, and in regular long runs.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_mode  <= 0;
      mode_left   <= 100;
      stall_phase <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          note_failure($sformatf("result with no query pending: threshold %0d",
                                 out_threshold_o));
        end else begin
          oldest_result = expected_results.pop_front();
          results_checked++;
          if (out_threshold_o !== oldest_result.threshold) begin
            note_failure($sformatf("threshold %0d, expected %0d", out_threshold_o,
                                   oldest_result.threshold));
          end
          if (out_ordered_value_o !== oldest_result.ordered) begin
            note_failure($sformatf("ordered_value %0d, expected %0d", out_ordered_value_o,
                                   oldest_result.ordered));
          end
          if (out_edge_case_o !== oldest_result.side) begin
            note_failure($sformatf("edge_case %0d, expected %0d", out_edge_case_o,
                                   oldest_result.side));
          end
          if (out_out_of_range_o !== oldest_result.oor) begin
            note_failure($sformatf("out_of_range %0b, expected %0b", out_out_of_range_o,
                                   oldest_result.oor));
          end
        end
      end
      if (mode_left == 0) begin
        stall_mode <= int'($urandom_range(0, 3));
        mode_left  <= int'($urandom_range(20, 300));
      end else begin
        mode_left <= mode_left - 1;
      end
      stall_phase <= stall_phase + 1;
      case (stall_mode)
        0:       out_stall_i <= 1'b0;
        1:       out_stall_i <= ($urandom_range(0, 3) == 0);
        2:       out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= ((stall_phase % 16) >= 10);
      endcase
    end
  end

  // Watchdog: any accepted word on either channel or a register access counts
  // as progress; a long stretch without any ends the run.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout after %0d cycles without progress.", IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Sequence: reset, reset values read back, the directed part, then random
  // phases under fresh settings. Each random phase is mostly queries on
  // windows that are known to be filled, with stray writes in between.
  initial begin : main_sequence
    int phase;
    int start;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    check_register(REG_SCALE);
    check_register(REG_LINE);
    check_register(REG_STRIDE);
    run_directed();
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      pick_settings();
      start = words_made;
      while (words_made - start < WORDS_PER_PHASE) begin
        if ($urandom_range(0, 9) < 3) begin
          push_write(ADDR_W'($urandom_range(0, MEM_DEPTH - 1)), pick_sample());
        end else begin
          push_query(pick_cut());
        end
      end
      drain_and_settle();
    end
    $display("Run covered %0d words, %0d of them queries (%0d out of range), %0d checked.",
             words_accepted, queries_seen, oor_seen, results_checked);
    $display("Window sides both/left/right: %0d/%0d/%0d; %0d register writes.",
             side_count[EDGE_BOTH], side_count[EDGE_LEFT], side_count[EDGE_RIGHT],
             reg_writes);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d failures, %0d results missing.", fail_count, expected_results.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
